### rtl/bale_pkg.sv
// Shared constants, codes and types of the bounded array list engine.
package bale_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int CMD_W  = 3;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int CAP_W  = 7;
    localparam int ST_W   = 3;
    localparam int CNT_W  = 7;
    localparam int CMP_W  = (LEN_W > CAP_W) ? LEN_W : CAP_W;
    localparam int GRP    = 8;
    localparam int GRP_W  = $clog2(GRP);
    localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
    localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int FIDX_W = NGRP_W + GRP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_APPEND = 3'd2,
        CMD_GET    = 3'd3,
        CMD_SET    = 3'd4,
        CMD_FIND   = 3'd5,
        CMD_CLEAR  = 3'd6
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REDUCE
    } t_state;

    typedef struct packed {
        logic ld_val;
        logic from_left;
        logic from_right;
    } t_cell_ctl;

endpackage

### rtl/bale_cfg_if.sv
// Configuration write channel carrying the capacity register.
interface bale_cfg_if;
    import bale_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;
    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

### rtl/bale_cmd_if.sv
// Command request channel into the list engine.
interface bale_cmd_if;
    import bale_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    modport source (output valid, output command, output position, output value, input ready);
    modport sink   (input valid, input command, input position, input value, output ready);
endinterface

### rtl/bale_res_if.sv
// Result request channel out of the list engine.
interface bale_res_if;
    import bale_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] data;
    logic [POS_W-1:0]        found_at;
    logic [CNT_W-1:0]        count;
    logic                    list_empty;
    logic                    is_full;
    modport source (output valid, output status, output data, output found_at,
                    output count, output list_empty, output is_full, input ready);
    modport sink   (input valid, input status, input data, input found_at,
                    input count, input list_empty, input is_full, output ready);
endinterface

### rtl/bale_cell.sv
// One storage cell of the list row: holds an entry, shifts and compares it.
module bale_cell (
    input  logic                         i_clk,
    input  bale_pkg::t_cell_ctl          i_ctl,
    input  logic [bale_pkg::VAL_W-1:0]   i_left,
    input  logic [bale_pkg::VAL_W-1:0]   i_right,
    input  logic [bale_pkg::VAL_W-1:0]   i_val,
    input  logic                         i_live,
    output logic [bale_pkg::VAL_W-1:0]   o_data,
    output logic                         o_match
);
    import bale_pkg::*;

    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ld_val) begin
            n_data = i_val;
        end else if (i_ctl.from_left) begin
            n_data = i_left;
        end else if (i_ctl.from_right) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = i_live && (r_data == i_val);

endmodule

### rtl/bounded_array_list_engine.sv
// Top level of the bounded array list engine: cell row, selection tree and control.
//
//  channel | direction | payload
//  i_cfg   | in        | capacity
//  i_cmd   | in        | command, position, value
//  o_res   | out       | status, data, found_at, count, list_empty, is_full
//
// Every command passes through acceptance, the cell row and the second level of the
// registered selection tree; no new command is accepted until it has left the last step.
// Reset clears the length, the capacity (to 64) and the control; the cells are not reset.
// A finished result waits in the output register while the next command is accepted;
// that command then holds in its last step until the output register is free.
module bounded_array_list_engine (
    input logic         i_clk,
    input logic         i_rst_n,
    bale_cfg_if.sink    i_cfg,
    bale_cmd_if.sink    i_cmd,
    bale_res_if.source  o_res
);
    import bale_pkg::*;

    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic [POS_W-1:0]    r_pos;
    logic [VAL_W-1:0]    r_val;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [CAP_W-1:0]    r_cap;
    t_status             r_status, n_status;
    logic                r_rd, n_rd;
    logic                r_find, n_find;

    logic [VAL_W-1:0]    r_grp_data [NGRP];
    logic [VAL_W-1:0]    n_grp_data [NGRP];
    logic                r_grp_hit  [NGRP];
    logic                n_grp_hit  [NGRP];
    logic [GRP_W-1:0]    r_grp_idx  [NGRP];
    logic [GRP_W-1:0]    n_grp_idx  [NGRP];

    logic                r_out_vld;
    t_status             r_out_status;
    logic [VAL_W-1:0]    r_out_data;
    logic [POS_W-1:0]    r_out_found;
    logic [CNT_W-1:0]    r_out_count;
    logic                r_out_empty;
    logic                r_out_full;

    logic [CMP_W-1:0]    len_x, pos_x, eff_cap, wpos;
    logic                full, exec, do_ins, do_del, do_set;
    logic                out_free;

    logic [VAL_W-1:0]    cell_data  [DEPTH];
    logic                cell_match [DEPTH];
    logic [DEPTH-1:0]    ld_vec;
    logic [VAL_W-1:0]    pad_data   [NGRP*GRP];
    logic                pad_match  [NGRP*GRP];

    logic [CMP_W-1:0]    grp_sel;
    logic [VAL_W-1:0]    sel_data;
    logic                hit_any;
    logic [FIDX_W-1:0]   hit_idx;

    assign len_x    = CMP_W'(r_len);
    assign pos_x    = CMP_W'(r_pos);
    assign eff_cap  = (CMP_W'(r_cap) < CMP_W'(DEPTH)) ? CMP_W'(r_cap) : CMP_W'(DEPTH);
    assign full     = len_x >= eff_cap;
    assign exec     = (r_state == S_EXEC);
    assign out_free = !r_out_vld || o_res.ready;

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = (r_state == S_IDLE);

    // Command decode in the cell-row cycle.
    always_comb begin
        n_status = ST_OK;
        n_len    = r_len;
        n_rd     = 1'b0;
        n_find   = 1'b0;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        do_set   = 1'b0;
        wpos     = pos_x;
        case (r_cmd)
            CMD_INSERT: begin
                if (pos_x > len_x) begin
                    n_status = ST_RANGE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            CMD_APPEND: begin
                wpos = len_x;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            CMD_DELETE: begin
                if (r_len == '0) begin
                    n_status = ST_EMPTY;
                end else if (pos_x >= len_x) begin
                    n_status = ST_RANGE;
                end else begin
                    do_del = 1'b1;
                    n_rd   = 1'b1;
                end
            end
            CMD_GET: begin
                if (pos_x >= len_x) begin
                    n_status = ST_RANGE;
                end else begin
                    n_rd = 1'b1;
                end
            end
            CMD_SET: begin
                if (pos_x >= len_x) begin
                    n_status = ST_RANGE;
                end else begin
                    do_set = 1'b1;
                end
            end
            CMD_FIND: begin
                n_find = 1'b1;
            end
            CMD_CLEAR: begin
                n_len = '0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        if (do_ins) begin
            n_len = r_len + LEN_W'(1);
        end else if (do_del) begin
            n_len = r_len - LEN_W'(1);
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_cell_ctl ctl;
        logic      live;
        assign ctl.ld_val     = exec && (do_ins || do_set) && (CMP_W'(i) == wpos);
        assign ctl.from_left  = exec && do_ins && (CMP_W'(i) > wpos);
        assign ctl.from_right = exec && do_del && (CMP_W'(i) >= pos_x);
        assign live           = CMP_W'(i) < len_x;
        assign ld_vec[i]      = ctl.ld_val;

        bale_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_left  ((i == 0) ? r_val : cell_data[(i == 0) ? 0 : i - 1]),
            .i_right ((i == DEPTH - 1) ? cell_data[i] : cell_data[(i == DEPTH - 1) ? i : i + 1]),
            .i_val   (r_val),
            .i_live  (live),
            .o_data  (cell_data[i]),
            .o_match (cell_match[i])
        );
    end

    for (genvar i = 0; i < NGRP * GRP; i++) begin : g_pad
        if (i < DEPTH) begin : g_real
            assign pad_data[i]  = cell_data[i];
            assign pad_match[i] = cell_match[i];
        end else begin : g_fill
            assign pad_data[i]  = '0;
            assign pad_match[i] = 1'b0;
        end
    end

    // First level of the selection tree: one entry and the first match per group.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp_data[g] = pad_data[g * GRP + int'(r_pos[GRP_W-1:0])];
            n_grp_hit[g]  = 1'b0;
            n_grp_idx[g]  = '0;
            for (int k = GRP - 1; k >= 0; k--) begin
                if (pad_match[g * GRP + k]) begin
                    n_grp_hit[g] = 1'b1;
                    n_grp_idx[g] = GRP_W'(k);
                end
            end
        end
    end

    // Second level of the selection tree.
    assign grp_sel = pos_x >> GRP_W;

    always_comb begin
        sel_data = '0;
        hit_any  = 1'b0;
        hit_idx  = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (CMP_W'(g) == grp_sel) begin
                sel_data = r_grp_data[g];
            end
        end
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_hit[g]) begin
                hit_any = 1'b1;
                hit_idx = {NGRP_W'(g), r_grp_idx[g]};
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_REDUCE;
            end
            S_REDUCE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_cap     <= CAP_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_cap <= i_cfg.capacity;
            end
            if (exec) begin
                r_len <= n_len;
            end
            if (r_state == S_REDUCE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd <= t_cmd'(i_cmd.command);
            r_pos <= i_cmd.position;
            r_val <= i_cmd.value;
        end
        if (exec) begin
            r_status   <= n_status;
            r_rd       <= n_rd;
            r_find     <= n_find;
            r_grp_data <= n_grp_data;
            r_grp_hit  <= n_grp_hit;
            r_grp_idx  <= n_grp_idx;
        end
        if (r_state == S_REDUCE && out_free) begin
            r_out_status <= (r_find && !hit_any) ? ST_NOTFOUND : r_status;
            r_out_data   <= r_rd ? sel_data : '0;
            r_out_found  <= (r_find && hit_any) ? POS_W'(hit_idx) : '0;
            r_out_count  <= CNT_W'(r_len);
            r_out_empty  <= (r_len == '0);
            r_out_full   <= full;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.status     = r_out_status;
    assign o_res.data       = r_out_data;
    assign o_res.found_at   = r_out_found;
    assign o_res.count      = r_out_count;
    assign o_res.list_empty = r_out_empty;
    assign o_res.is_full    = r_out_full;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        len_x <= CMP_W'(DEPTH))
        else $error("list length beyond the cell row");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter the cell row");

    a_len_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_state != S_EXEC) |=> $stable(r_len))
        else $error("length changed outside the cell-row cycle");

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(ld_vec))
        else $error("more than one cell loads the request value");

    a_notfound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status == ST_NOTFOUND) |-> (r_out_found == '0 && r_out_data == '0))
        else $error("failed find reports a position or data");

endmodule

### verif/tb_top.sv
// Self-checking testbench of the bounded array list engine, predicting every command's result.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bale_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_AT      = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [CMD_W-1:0]        op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
    } t_list_cmd;

    typedef struct {
        t_status                 status;
        logic signed [VAL_W-1:0] data;
        logic [POS_W-1:0]        found_at;
        logic [CNT_W-1:0]        count;
        logic                    list_empty;
        logic                    is_full;
    } t_list_reply;

    logic i_clk;
    logic i_rst_n = 1'b0;

    bale_cfg_if cfg_bus ();
    bale_cmd_if cmd_bus ();
    bale_res_if res_bus ();

    bounded_array_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    t_list_cmd               pending_cmds[$];
    t_list_reply             expected_replies[$];
    logic signed [VAL_W-1:0] list_cells [DEPTH];
    logic signed [VAL_W-1:0] value_pool [8];
    int                      list_len;
    int                      cap_value;

    int errors;
    int r_cmds_accepted;
    int replies_checked;
    int settings_used;
    int r_cycle_count;
    int status_seen [5];
    int r_tx_gap;
    int r_rx_gap;
    int r_hold_left;
    bit tx_quiet;
    bit rx_quiet;
    bit r_hold_done;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_list_reply apply_command(t_list_cmd c);
        t_list_reply r;
        int          eff_cap;
        int          slot;
        int          i;
        r.status   = ST_OK;
        r.data     = '0;
        r.found_at = '0;
        eff_cap    = (cap_value < DEPTH) ? cap_value : DEPTH;
        case (c.op)
            CMD_INSERT, CMD_APPEND: begin
                slot = (c.op == CMD_APPEND) ? list_len : int'(c.pos);
                if (slot > list_len) begin
                    r.status = ST_RANGE;
                end else if (list_len >= eff_cap) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > slot; i--) list_cells[i] = list_cells[i-1];
                    list_cells[slot] = c.val;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (int'(c.pos) >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.data = list_cells[c.pos];
                    for (i = int'(c.pos); i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
                    list_len--;
                end
            end
            CMD_GET: begin
                if (int'(c.pos) >= list_len) r.status = ST_RANGE;
                else r.data = list_cells[c.pos];
            end
            CMD_SET: begin
                if (int'(c.pos) >= list_len) r.status = ST_RANGE;
                else list_cells[c.pos] = c.val;
            end
            CMD_FIND: begin
                r.status = ST_NOTFOUND;
                for (i = 0; i < list_len; i++) begin
                    if (list_cells[i] == c.val) begin
                        r.status   = ST_OK;
                        r.found_at = POS_W'(i);
                        break;
                    end
                end
            end
            CMD_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        r.count      = CNT_W'(list_len);
        r.list_empty = (list_len == 0);
        r.is_full    = (list_len >= eff_cap);
        return r;
    endfunction

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 16));
    endfunction

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            errors++;
        end
    endtask

    task automatic queue_cmd(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                             logic signed [VAL_W-1:0] val);
        t_list_cmd c;
        c.op  = op;
        c.pos = pos;
        c.val = val;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_random(int n, int grow_pct, int span, bit quiet_tx, bit quiet_rx);
        logic [CMD_W-1:0]        op;
        logic signed [VAL_W-1:0] val;
        int                      pick;
        @(negedge i_clk);
        tx_quiet = quiet_tx;
        rx_quiet = quiet_rx;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < grow_pct) begin
                op = $urandom_range(0, 1) ? CMD_INSERT : CMD_APPEND;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 30)      op = CMD_DELETE;
                else if (pick < 50) op = CMD_GET;
                else if (pick < 70) op = CMD_SET;
                else if (pick < 98) op = CMD_FIND;
                else if (pick < 99) op = CMD_CLEAR;
                else                op = CMD_UNUSED;
            end
            val = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 7)] : $urandom;
            queue_cmd(op, POS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                              : $urandom_range(0, span)), val);
        end
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        @(posedge i_clk);
        cfg_bus.valid    <= 1'b1;
        cfg_bus.capacity <= v;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        cap_value = v;
        settings_used++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (pending_cmds.size() != 0 || cmd_bus.valid || expected_replies.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_cmds
        t_list_cmd taken;
        t_list_cmd nxt;
        int        gap;
        if (!i_rst_n) begin
            cmd_bus.valid    <= 1'b0;
            cmd_bus.command  <= '0;
            cmd_bus.position <= '0;
            cmd_bus.value    <= '0;
            r_tx_gap         <= 0;
        end else if (!(cmd_bus.valid && !cmd_bus.ready)) begin
            gap = r_tx_gap;
            if (cmd_bus.valid) begin
                taken.op  = cmd_bus.command;
                taken.pos = cmd_bus.position;
                taken.val = cmd_bus.value;
                expected_replies.push_back(apply_command(taken));
                r_cmds_accepted <= r_cmds_accepted + 1;
                gap = draw_gap(tx_quiet);
            end
            if (gap == 0 && pending_cmds.size() != 0) begin
                nxt = pending_cmds.pop_front();
                cmd_bus.valid    <= 1'b1;
                cmd_bus.command  <= nxt.op;
                cmd_bus.position <= nxt.pos;
                cmd_bus.value    <= nxt.val;
                r_tx_gap         <= 0;
            end else begin
                cmd_bus.valid <= 1'b0;
                r_tx_gap      <= (gap > 0) ? gap - 1 : 0;
            end
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_list_reply want;
        int          gap;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            r_rx_gap      <= 0;
        end else begin
            gap = r_rx_gap;
            if (res_bus.valid && res_bus.ready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: result with no command waiting for it, status %h",
                             $time, res_bus.status);
                    errors++;
                end else begin
                    want = expected_replies.pop_front();
                    replies_checked++;
                    if (res_bus.status <= ST_NOTFOUND) status_seen[res_bus.status]++;
                    compare_field("status", want.status, res_bus.status);
                    compare_field("data", want.data, res_bus.data);
                    compare_field("found_at", want.found_at, res_bus.found_at);
                    compare_field("count", want.count, res_bus.count);
                    compare_field("list_empty", want.list_empty, res_bus.list_empty);
                    compare_field("is_full", want.is_full, res_bus.is_full);
                end
                gap = draw_gap(rx_quiet);
            end
            if (gap == 0) begin
                res_bus.ready <= (r_hold_left == 0);
                r_rx_gap      <= 0;
            end else begin
                res_bus.ready <= 1'b0;
                r_rx_gap      <= gap - 1;
            end
        end
    end

    // The receiver refuses results for a long stretch once, so that the engine backs up.
    always @(posedge i_clk) begin : hold_results
        if (!i_rst_n) begin
            r_hold_left <= 0;
            r_hold_done <= 1'b0;
        end else if (!r_hold_done && r_cmds_accepted >= HOLD_AT) begin
            r_hold_left <= HOLD_CYCLES;
            r_hold_done <= 1'b1;
        end else if (r_hold_left > 0) begin
            r_hold_left <= r_hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : watchdog
        r_cycle_count <= r_cycle_count + 1;
        if (r_cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles without finishing", CYCLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin : run_phases
        int i;
        cfg_bus.valid    = 1'b0;
        cfg_bus.capacity = CAP_RESET;
        cmd_bus.valid    = 1'b0;
        cmd_bus.command  = '0;
        cmd_bus.position = '0;
        cmd_bus.value    = '0;
        res_bus.ready    = 1'b0;
        tx_quiet         = 1'b0;
        rx_quiet         = 1'b0;
        cap_value        = CAP_RESET;
        list_len         = 0;
        value_pool[0]    = 32'sh8000_0000;
        value_pool[1]    = 32'sh7fff_ffff;
        value_pool[2]    = -1;
        value_pool[3]    = 0;
        for (i = 4; i < 8; i++) value_pool[i] = $urandom;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A capacity of three reaches the full list within a few requests.
        write_capacity(7'd3);
        @(negedge i_clk);
        queue_cmd(CMD_DELETE, 0, 0);
        queue_cmd(CMD_FIND, 0, 0);
        queue_cmd(CMD_GET, 0, 0);
        queue_cmd(CMD_SET, 63, -1);
        queue_cmd(CMD_INSERT, 1, 5);
        queue_cmd(CMD_INSERT, 0, 32'sh8000_0000);
        queue_cmd(CMD_APPEND, 63, 32'sh7fff_ffff);
        queue_cmd(CMD_INSERT, 1, -1);
        queue_cmd(CMD_APPEND, 0, 5);
        queue_cmd(CMD_INSERT, 63, 5);
        queue_cmd(CMD_INSERT, 3, 5);
        queue_cmd(CMD_FIND, 0, -1);
        queue_cmd(CMD_FIND, 0, 32'sh7fff_ffff);
        queue_cmd(CMD_FIND, 0, 12345);
        queue_cmd(CMD_GET, 2, 0);
        queue_cmd(CMD_SET, 0, 0);
        queue_cmd(CMD_GET, 3, 0);
        queue_cmd(CMD_DELETE, 63, 0);
        queue_cmd(CMD_DELETE, 1, 0);
        queue_cmd(CMD_UNUSED, 63, -1);
        queue_cmd(CMD_DELETE, 0, 0);
        queue_cmd(CMD_DELETE, 0, 0);
        queue_cmd(CMD_APPEND, 0, 42);
        queue_cmd(CMD_CLEAR, 0, 0);
        queue_cmd(CMD_CLEAR, 63, 0);
        settle();

        write_capacity(7'd0);
        queue_random(30, 50, 3, 1'b0, 1'b0);
        settle();

        write_capacity(7'd1);
        queue_random(60, 50, 2, 1'b1, 1'b1);
        settle();

        write_capacity(7'd64);
        queue_random(260, 62, 63, 1'b1, 1'b0);
        queue_cmd(CMD_CLEAR, 0, 0);
        repeat (40) queue_cmd(CMD_APPEND, POS_W'($urandom_range(0, 63)), $urandom);
        settle();

        // The capacity now drops below the length, and the entries stay in place.
        write_capacity(7'd20);
        queue_random(150, 40, 40, 1'b0, 1'b0);
        settle();

        write_capacity(7'd127);
        queue_random(120, 60, 63, 1'b0, 1'b0);
        settle();

        write_capacity(CAP_W'($urandom_range(2, 63)));
        queue_random(150, 55, cap_value, 1'b0, 1'b0);
        settle();

        write_capacity(7'd64);
        queue_random(60, 50, 63, 1'b1, 1'b1);
        settle();

        $display("Checked %0d results of %0d commands under %0d capacity settings, %0d mismatches.",
                 replies_checked, r_cmds_accepted, settings_used, errors);
        $display("Statuses seen: ok %0d, out of range %0d, full %0d, empty %0d, not found %0d.",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL],
                 status_seen[ST_EMPTY], status_seen[ST_NOTFOUND]);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
